/* src/qsu_pkg.sv */
// Package for the quoted string unescaper.
// Holds the phase type, status codes, character constants and decode helpers.
// Depends on nothing; used by the top level.
`timescale 1ns / 1ps

package qsu_pkg;

    // Decoder phase; the one unused code behaves as the error phase.
    typedef enum logic [2:0] {
        PH_OPEN   = 3'd0,
        PH_BODY   = 3'd1,
        PH_ESC    = 3'd2,
        PH_HEX1   = 3'd3,
        PH_HEX2   = 3'd4,
        PH_CLOSED = 3'd5,
        PH_ERROR  = 3'd6
    } phase_t;

    // Status codes reported with each result item.
    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_OK   = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    // Characters that the decoder recognizes.
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;

    // Result of decoding one hex digit.
    typedef struct packed {
        logic       ok;
        logic [3:0] nibble;
    } hex_digit_t;

    // Result of mapping a simple escape byte.
    typedef struct packed {
        logic       ok;
        logic [7:0] value;
    } escape_t;

    // Hex digit in either case.
    function automatic hex_digit_t hex_value(input logic [7:0] b);
        hex_digit_t r;
        logic [7:0] diff;
        r    = '0;
        diff = '0;
        case (b) inside
            [8'h30:8'h39]:
            begin
                diff   = b - 8'h30;
                r.ok   = 1'b1;
                r.nibble = diff[3:0];
            end
            [8'h61:8'h66]:
            begin
                diff   = b - 8'h57;
                r.ok   = 1'b1;
                r.nibble = diff[3:0];
            end
            [8'h41:8'h46]:
            begin
                diff   = b - 8'h37;
                r.ok   = 1'b1;
                r.nibble = diff[3:0];
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    // Single-character escapes: n f r t v a b 0, both quotes and backslash.
    function automatic escape_t simple_escape(input logic [7:0] b);
        escape_t r;
        r.ok = 1'b1;
        unique case (b)
            8'h6E: r.value = 8'h0A;        // n
            8'h66: r.value = 8'h0C;        // f
            8'h72: r.value = 8'h0D;        // r
            8'h74: r.value = 8'h09;        // t
            8'h76: r.value = 8'h0B;        // v
            8'h61: r.value = 8'h07;        // a
            8'h62: r.value = 8'h08;        // b
            8'h30: r.value = 8'h00;        // 0
            CH_DQUOTE:    r.value = CH_DQUOTE;
            CH_SQUOTE:    r.value = CH_SQUOTE;
            CH_BACKSLASH: r.value = CH_BACKSLASH;
            default:
            begin
                r.ok    = 1'b0;
                r.value = 8'h00;
            end
        endcase
        return r;
    endfunction

endpackage

/* src/qsu_byte_if.sv */
// Valid/ready channel that carries one raw byte of a quoted literal per item.
// Standalone; used by the top level of the quoted string unescaper.
`timescale 1ns / 1ps

interface qsu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, in_byte, end_of_text, input ready);
    modport sink   (input valid, in_byte, end_of_text, output ready);
endinterface

/* src/qsu_char_if.sv */
// Valid/ready channel that carries one decoded result per item.
// Standalone; used by the top level of the quoted string unescaper.
`timescale 1ns / 1ps

interface qsu_char_if;
    logic       valid;
    logic       ready;
    logic       char_valid;
    logic [7:0] char_value;
    logic [1:0] status;
    logic       end_mark;

    modport source (output valid, char_valid, char_value, status, end_mark, input ready);
    modport sink   (input valid, char_valid, char_value, status, end_mark, output ready);
endinterface

/* src/quoted_string_unescaper.sv */
// Quoted string unescaper: one raw byte in, one decoded result out per item.
// The path holds an input register, then the decode into a result register.
// Throughput is one item per cycle while char_stream.ready does not stall it;
// the decoder state registers are the only loop and close through a single small decode.
// Reset (rst_n, asynchronous, active low) empties both registers and returns
// the decoder to the expect-opening-quote phase; the final byte of each
// literal does the same to the decoder state.
`timescale 1ns / 1ps

module quoted_string_unescaper (
    input  logic       clk,
    input  logic       rst_n,
    qsu_byte_if.sink   byte_stream,
    qsu_char_if.source char_stream
);
    import qsu_pkg::*;

    // Input register.
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Decoder state.
    phase_t     phase_reg, phase_next;
    logic       dquote_reg, dquote_next;
    logic [3:0] nibble_reg, nibble_next;

    // Result register.
    logic       out_vld_reg;
    logic       out_char_vld_reg;
    logic [7:0] out_char_reg;
    status_t    out_status_reg;
    logic       out_end_reg;

    // Decode outputs.
    logic       dec_char_vld;
    logic [7:0] dec_char;
    status_t    dec_status;
    hex_digit_t hex;
    escape_t    esc;
    logic [7:0] quote_char;

    logic       advance;
    logic       take_in;

    // The result register moves when it is empty or being drained.
    assign advance = !out_vld_reg || char_stream.ready;
    assign take_in = byte_stream.valid && byte_stream.ready;
    assign byte_stream.ready = !in_vld_reg || advance;

    assign hex        = hex_value(in_byte_reg);
    assign esc        = simple_escape(in_byte_reg);
    assign quote_char = dquote_reg ? CH_DQUOTE : CH_SQUOTE;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (byte_stream.ready)
        begin
            in_vld_reg <= byte_stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_byte_reg <= byte_stream.in_byte;
            in_last_reg <= byte_stream.end_of_text;
        end
    end

    // Next phase and stored quote and hex nibble.
    always_comb
    begin
        phase_next  = phase_reg;
        dquote_next = dquote_reg;
        nibble_next = nibble_reg;
        unique case (phase_reg)
            PH_OPEN:
            begin
                if (in_byte_reg == CH_DQUOTE || in_byte_reg == CH_SQUOTE)
                begin
                    dquote_next = (in_byte_reg == CH_DQUOTE);
                    phase_next  = PH_BODY;
                end
                else
                begin
                    phase_next = PH_ERROR;
                end
            end
            PH_BODY:
            begin
                if (in_byte_reg == quote_char)
                begin
                    phase_next = PH_CLOSED;
                end
                else if (in_byte_reg == CH_BACKSLASH)
                begin
                    phase_next = in_last_reg ? PH_ERROR : PH_ESC;
                end
            end
            PH_ESC:
            begin
                if (in_byte_reg == CH_X)
                begin
                    phase_next = in_last_reg ? PH_ERROR : PH_HEX1;
                end
                else if (esc.ok)
                begin
                    phase_next = PH_BODY;
                end
                else
                begin
                    phase_next = PH_ERROR;
                end
            end
            PH_HEX1:
            begin
                if (!hex.ok || in_last_reg)
                begin
                    phase_next = PH_ERROR;
                end
                else
                begin
                    nibble_next = hex.nibble;
                    phase_next  = PH_HEX2;
                end
            end
            PH_HEX2:
            begin
                phase_next = hex.ok ? PH_BODY : PH_ERROR;
            end
            default:
            begin
                phase_next = PH_ERROR;
            end
        endcase
    end

    // Decoded character and status.
    always_comb
    begin
        dec_char_vld = 1'b0;
        dec_char     = 8'h00;
        unique case (phase_reg)
            PH_BODY:
            begin
                if (in_byte_reg != quote_char && in_byte_reg != CH_BACKSLASH)
                begin
                    dec_char_vld = 1'b1;
                    dec_char     = in_byte_reg;
                end
            end
            PH_ESC:
            begin
                if (in_byte_reg != CH_X && esc.ok)
                begin
                    dec_char_vld = 1'b1;
                    dec_char     = esc.value;
                end
            end
            PH_HEX2:
            begin
                if (hex.ok)
                begin
                    dec_char_vld = 1'b1;
                    dec_char     = {nibble_reg, hex.nibble};
                end
            end
            default:
            begin
                dec_char_vld = 1'b0;
            end
        endcase

        if (!in_last_reg)
        begin
            dec_status = ST_BUSY;
        end
        else if (phase_next == PH_ERROR)
        begin
            dec_status = ST_BAD;
        end
        else
        begin
            dec_status = ST_OK;
        end
    end

    // Decoder state: the final byte of a literal returns it to reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_OPEN;
            dquote_reg <= 1'b0;
            nibble_reg <= 4'h0;
        end
        else if (advance && in_vld_reg)
        begin
            if (in_last_reg)
            begin
                phase_reg  <= PH_OPEN;
                dquote_reg <= 1'b0;
                nibble_reg <= 4'h0;
            end
            else
            begin
                phase_reg  <= phase_next;
                dquote_reg <= dquote_next;
                nibble_reg <= nibble_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_vld_reg)
        begin
            out_char_vld_reg <= dec_char_vld;
            out_char_reg     <= dec_char;
            out_status_reg   <= dec_status;
            out_end_reg      <= in_last_reg;
        end
    end

    assign char_stream.valid      = out_vld_reg;
    assign char_stream.char_valid = out_char_vld_reg;
    assign char_stream.char_value = out_char_reg;
    assign char_stream.status     = out_status_reg;
    assign char_stream.end_mark   = out_end_reg;

    // A final status appears exactly on the item that ends a literal.
    a_status_on_end : assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_end_reg == (out_status_reg != ST_BUSY)))
        else $error("status and end mark disagree");

    // A character with no valid flag reads as zero.
    a_char_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_char_vld_reg) |-> (out_char_reg == 8'h00))
        else $error("char value nonzero without a character");

    // The final byte of a literal brings the decoder back to the opening phase.
    a_restart : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_vld_reg && in_last_reg) |=> (phase_reg == PH_OPEN))
        else $error("decoder did not restart after the final byte");

    // A result only leaves the input register when the result register moves.
    a_no_drop : assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !advance) |=> (in_vld_reg && $stable(in_byte_reg)))
        else $error("stalled item lost from the input register");

endmodule
